// File: hw/rtl/spherical_uv_mapper_top_defines.svh
// Assertion helpers for the mapper's top-level RTL.
`ifndef SPHERICAL_UV_MAPPER_TOP_DEFINES_SVH
`define SPHERICAL_UV_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPM_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("spm assertion failed");

// Next-cycle implication, checked outside reset.
`define SPM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("spm assertion failed");

`endif

// File: hw/rtl/spm_pkg.sv
package spm_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_BOX_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_BOX_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_BOX_DEPTH  = 2'd2;

    // Fixed-point formats: coordinates are scaled into a 32-bit word.
    localparam int SCALED_W = 32;
    localparam int N_W      = 64;   // radicand of the square root
    localparam int ROOT_W   = 32;   // radius bits
    localparam int REM_W    = 36;   // square-root partial remainder
    localparam int CIN_W    = 33;   // CORDIC operand width (radius is unsigned 32 bits)
    localparam int CD_W     = 36;   // CORDIC datapath width, covers the gain growth
    localparam int ANG_W    = 34;   // angle, one turn is 2^32

    localparam int TEX_W   = 16;
    localparam int TEX_MAX = 2**TEX_W - 1;

    localparam int ATAN_ENTRIES = 32;

    // Angle of atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    localparam logic signed [ANG_W-1:0] HALF_TURN = {{(ANG_W-32){1'b0}}, 32'h8000_0000};

    // One result item.
    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             degen;
    } t_tex_item;

endpackage

// File: hw/rtl/spherical_uv_mapper_top.sv
// Channel   Dir  Handshake                    Payload
// input     in   i_in_valid / o_in_stall      i_pos_x, i_pos_y, i_pos_z
// result    out  o_out_valid / i_out_stall    o_tex_u, o_tex_v, o_box_degenerate
// config    in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item per cycle is accepted while the output side keeps up.
// The pipeline has two square-and-sum stages, 32 square-root stages (one root bit
// each), CORDIC_STEPS + 1 CORDIC stages and the output register.
// Synchronous active-low reset clears all valid bits and marks every box extent as nonzero.
// When the result is stalled, one more item parks in a skid register; the pipeline
// then holds until it drains, and no item is lost or repeated.
`include "spherical_uv_mapper_top_defines.svh"

module spherical_uv_mapper_top
    import spm_pkg::*;
#(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [TEX_W-1:0]              o_tex_u,
    output logic [TEX_W-1:0]              o_tex_v,
    output logic                          o_box_degenerate,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int FRAC_SHIFT = SCALED_W - COORD_WIDTH;
    localparam int SQ_W       = 2 * COORD_WIDTH;
    localparam int SIDE_W     = 3 * COORD_WIDTH;
    localparam int DEGEN_LAT  = ROOT_W + CORDIC_STEPS + 1;
    localparam logic signed [ANG_W:0] U_ROUND = (ANG_W+1)'(2**15);
    localparam logic signed [ANG_W:0] V_ROUND = (ANG_W+1)'(2**14);

    // Clamp a shifted angle into the unsigned texture range.
    function automatic logic [TEX_W-1:0] sat_tex(input logic signed [ANG_W:0] val);
        logic signed [ANG_W:0] lim;
        lim = (ANG_W+1)'(TEX_MAX);
        if (val[ANG_W]) begin
            return '0;
        end else if (val > lim) begin
            return '1;
        end else begin
            return val[TEX_W-1:0];
        end
    endfunction

    logic en;
    logic hold;

    // Configuration: only the zero test of each extent matters.
    logic r_width_zero;
    logic r_height_zero;
    logic r_depth_zero;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_zero  <= 1'b0;
            r_height_zero <= 1'b0;
            r_depth_zero  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BOX_WIDTH:  r_width_zero  <= (i_cfg_data == '0);
                CFG_BOX_HEIGHT: r_height_zero <= (i_cfg_data == '0);
                CFG_BOX_DEPTH:  r_depth_zero  <= (i_cfg_data == '0);
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances unless the skid register is full.
    assign en         = !hold;
    assign o_in_stall = hold;

    // Stage 1: squares of x and y.
    logic signed [SQ_W-1:0]        x_ext;
    logic signed [SQ_W-1:0]        y_ext;
    logic signed [SQ_W-1:0]        n_s1_xx;
    logic signed [SQ_W-1:0]        n_s1_yy;
    logic                          r_s1_valid;
    logic [SQ_W-1:0]               r_s1_xx;
    logic [SQ_W-1:0]               r_s1_yy;
    logic signed [COORD_WIDTH-1:0] r_s1_x;
    logic signed [COORD_WIDTH-1:0] r_s1_y;
    logic signed [COORD_WIDTH-1:0] r_s1_z;
    logic                          r_s1_degen;

    assign x_ext   = SQ_W'(i_pos_x);
    assign y_ext   = SQ_W'(i_pos_y);
    assign n_s1_xx = x_ext * x_ext;
    assign n_s1_yy = y_ext * y_ext;

    // Stage 2: sum of squares.
    logic                          r_s2_valid;
    logic [SQ_W-1:0]               r_s2_sq;
    logic signed [COORD_WIDTH-1:0] r_s2_x;
    logic signed [COORD_WIDTH-1:0] r_s2_y;
    logic signed [COORD_WIDTH-1:0] r_s2_z;
    logic                          r_s2_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_xx    <= n_s1_xx;
            r_s1_yy    <= n_s1_yy;
            r_s1_x     <= i_pos_x;
            r_s1_y     <= i_pos_y;
            r_s1_z     <= i_pos_z;
            r_s1_degen <= r_width_zero || r_height_zero || r_depth_zero;
            r_s2_sq    <= r_s1_xx + r_s1_yy;
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            r_s2_z     <= r_s1_z;
            r_s2_degen <= r_s1_degen;
        end
    end

    // Radius with the same scale as the coordinates.
    logic [N_W-1:0]    sqrt_n;
    logic              sqrt_valid;
    logic [ROOT_W-1:0] root;

    assign sqrt_n = N_W'(r_s2_sq) << (2 * FRAC_SHIFT);

    spm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_valid),
        .i_n     (sqrt_n),
        .o_valid (sqrt_valid),
        .o_root  (root)
    );

    // Coordinates wait alongside the square root.
    logic [SIDE_W-1:0]             side_q;
    logic signed [COORD_WIDTH-1:0] d_x;
    logic signed [COORD_WIDTH-1:0] d_y;
    logic signed [COORD_WIDTH-1:0] d_z;
    logic                          degen_q;

    spm_delay #(
        .WIDTH (SIDE_W),
        .DEPTH (ROOT_W)
    ) u_coord_delay (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_s2_x, r_s2_y, r_s2_z}),
        .o_data (side_q)
    );

    spm_delay #(
        .WIDTH (1),
        .DEPTH (DEGEN_LAT)
    ) u_degen_delay (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (r_s2_degen),
        .o_data (degen_q)
    );

    assign d_x = side_q[SIDE_W-1 -: COORD_WIDTH];
    assign d_y = side_q[2*COORD_WIDTH-1 -: COORD_WIDTH];
    assign d_z = side_q[COORD_WIDTH-1:0];

    // Azimuth atan2(x, y) and polar angle atan2(r, z).
    logic signed [CIN_W-1:0] u_xa;
    logic signed [CIN_W-1:0] u_ya;
    logic signed [CIN_W-1:0] v_xa;
    logic signed [CIN_W-1:0] v_ya;
    logic                    u_valid;
    logic                    v_valid;
    logic signed [ANG_W-1:0] u_angle;
    logic signed [ANG_W-1:0] v_angle;

    assign u_xa = CIN_W'(d_y) <<< FRAC_SHIFT;
    assign u_ya = CIN_W'(d_x) <<< FRAC_SHIFT;
    assign v_xa = CIN_W'(d_z) <<< FRAC_SHIFT;
    assign v_ya = $signed(CIN_W'(root));

    spm_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_valid),
        .i_xa    (u_xa),
        .i_ya    (u_ya),
        .o_valid (u_valid),
        .o_angle (u_angle)
    );

    spm_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_valid),
        .i_xa    (v_xa),
        .i_ya    (v_ya),
        .o_valid (v_valid),
        .o_angle (v_angle)
    );

    // Round, shift and clamp into the output item.
    logic signed [ANG_W:0] u_sum;
    logic signed [ANG_W:0] v_sum;
    t_tex_item             fin_item;
    t_tex_item             out_item;

    assign u_sum = (ANG_W+1)'(u_angle) + (ANG_W+1)'(HALF_TURN) + U_ROUND;
    assign v_sum = (ANG_W+1)'(v_angle) + V_ROUND;

    always_comb begin
        fin_item.degen = degen_q;
        if (degen_q) begin
            fin_item.tex_u = '0;
            fin_item.tex_v = '0;
        end else begin
            fin_item.tex_u = sat_tex(u_sum >>> 16);
            fin_item.tex_v = sat_tex(v_sum >>> 15);
        end
    end

    spm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (u_valid),
        .i_item  (fin_item),
        .o_hold  (hold),
        .o_valid (o_out_valid),
        .o_item  (out_item),
        .i_stall (i_out_stall)
    );

    assign o_tex_u          = out_item.tex_u;
    assign o_tex_v          = out_item.tex_v;
    assign o_box_degenerate = out_item.degen;

    // Both angle pipelines carry the same item.
    `SPM_ASSERT_IMPLY(a_lanes_aligned, i_clk, i_rst_n, u_valid || v_valid, u_valid && v_valid)
    // A parked item implies a waiting result.
    `SPM_ASSERT_IMPLY(a_hold_has_out, i_clk, i_rst_n, hold, o_out_valid)
    // A taken result frees the skid register.
    `SPM_ASSERT_NEXT(a_hold_drains, i_clk, i_rst_n, hold && !i_out_stall, !hold)
    // A degenerate box forces both coordinates to zero.
    `SPM_ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_box_degenerate,
                      o_tex_u == '0 && o_tex_v == '0)

endmodule

// File: hw/rtl/spm_delay.sv
module spm_delay
    import spm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // Shift line that advances with the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// File: hw/rtl/spm_isqrt.sv
module spm_isqrt
    import spm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [N_W-1:0]    i_n,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root
);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_step;

    // One restoring square-root digit: bring down two radicand bits, try a one.
    function automatic t_step sqrt_step(input logic [REM_W-1:0] rem,
                                        input logic [ROOT_W-1:0] root,
                                        input logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        t_step res;
        rem_sh = {rem[REM_W-3:0], pair};
        trial  = REM_W'({root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    logic [N_W-1:0]    r_n    [ROOT_W-1];
    logic [N_W-1:0]    n_n    [ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [REM_W-1:0]  n_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W-1];
    logic [ROOT_W-1:0] n_root [ROOT_W-1];
    logic [ROOT_W-1:0] r_last_root;
    logic [ROOT_W-1:0] n_last_root;
    logic              r_valid [ROOT_W];

    // Each stage settles one root bit from the previous stage's registers.
    always_comb begin : p_next
        t_step st;
        st = sqrt_step('0, '0, i_n[N_W-1 -: 2]);
        n_rem[0]  = st.rem;
        n_root[0] = st.root;
        n_n[0]    = i_n << 2;
        for (int k = 1; k < ROOT_W - 1; k++) begin
            st = sqrt_step(r_rem[k-1], r_root[k-1], r_n[k-1][N_W-1 -: 2]);
            n_rem[k]  = st.rem;
            n_root[k] = st.root;
            n_n[k]    = r_n[k-1] << 2;
        end
        st = sqrt_step(r_rem[ROOT_W-2], r_root[ROOT_W-2], r_n[ROOT_W-2][N_W-1 -: 2]);
        n_last_root = st.root;
    end

    // Valid bits travel with the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < ROOT_W; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W - 1; k++) begin
                r_n[k]    <= n_n[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            r_last_root <= n_last_root;
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_last_root;

endmodule

// File: hw/rtl/spm_cordic.sv
module spm_cordic
    import spm_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [CIN_W-1:0] i_xa,
    input  logic signed [CIN_W-1:0] i_ya,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_angle
);

    logic signed [CD_W-1:0]  r_x   [STEPS];
    logic signed [CD_W-1:0]  n_x   [STEPS];
    logic signed [CD_W-1:0]  r_y   [STEPS];
    logic signed [CD_W-1:0]  n_y   [STEPS];
    logic                    r_zero [STEPS];
    logic                    n_zero [STEPS];
    logic signed [ANG_W-1:0] r_acc [STEPS+1];
    logic signed [ANG_W-1:0] n_acc [STEPS+1];
    logic                    r_valid [STEPS+1];

    always_comb begin : p_next
        logic signed [CD_W-1:0]  xa;
        logic signed [CD_W-1:0]  ya;
        logic signed [CD_W-1:0]  dx;
        logic signed [CD_W-1:0]  dy;
        logic signed [ANG_W-1:0] step_ang;
        // Entry stage: the left half plane is turned by a half turn first.
        xa = CD_W'(i_xa);
        ya = CD_W'(i_ya);
        n_zero[0] = (i_xa == '0) && (i_ya == '0);
        if (i_xa[CIN_W-1]) begin
            n_acc[0] = i_ya[CIN_W-1] ? -HALF_TURN : HALF_TURN;
            n_x[0]   = -xa;
            n_y[0]   = -ya;
        end else begin
            n_acc[0] = '0;
            n_x[0]   = xa;
            n_y[0]   = ya;
        end
        // Angle accumulation; the origin vector gives angle zero.
        for (int k = 0; k < STEPS; k++) begin
            step_ang = $signed(ANG_W'(ATAN_TURNS[k]));
            if (r_y[k][CD_W-1]) begin
                n_acc[k+1] = r_acc[k] - step_ang;
            end else begin
                n_acc[k+1] = r_acc[k] + step_ang;
            end
            if ((k == STEPS - 1) && r_zero[k]) begin
                n_acc[k+1] = '0;
            end
        end
        // Vector rotation toward the positive x axis.
        for (int k = 0; k < STEPS - 1; k++) begin
            dx = r_y[k] >>> k;
            dy = r_x[k] >>> k;
            if (r_y[k][CD_W-1]) begin
                n_x[k+1] = r_x[k] - dx;
                n_y[k+1] = r_y[k] + dy;
            end else begin
                n_x[k+1] = r_x[k] + dx;
                n_y[k+1] = r_y[k] - dy;
            end
            n_zero[k+1] = r_zero[k];
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 0; k < STEPS; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STEPS; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_zero[k] <= n_zero[k];
            end
            for (int k = 0; k <= STEPS; k++) begin
                r_acc[k] <= n_acc[k];
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_angle = r_acc[STEPS];

endmodule

// File: hw/rtl/spm_skid.sv
module spm_skid
    import spm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_tex_item i_item,
    output logic      o_hold,
    output logic      o_valid,
    output t_tex_item o_item,
    input  logic      i_stall
);

    logic      r_out_valid;
    logic      n_out_valid;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_tex_item r_out;
    t_tex_item n_out;
    t_tex_item r_skid;
    logic      take;
    logic      push;
    logic      load_out;
    logic      load_skid;
    logic      sel_skid;

    assign take = r_out_valid && !i_stall;
    assign push = i_valid && !r_skid_valid;

    // The skid register catches an item when the output register is blocked.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        sel_skid     = 1'b0;
        if (r_skid_valid) begin
            if (take) begin
                load_out     = 1'b1;
                sel_skid     = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
        n_out = sel_skid ? r_skid : i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
        if (load_skid) begin
            r_skid <= i_item;
        end
    end

    assign o_hold  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
